// ===== src/nfa_pkg.sv =====
package nfa_pkg;

   localparam int NUM_STATES  = 16;
   localparam int STATE_W     = 4;
   localparam int SYM_W       = 8;
   localparam int ADDR_W      = STATE_W + SYM_W;
   localparam int STORE_DEPTH = 1 << ADDR_W;
   localparam int MASK_W      = 16;
   localparam int SCAN_W      = $clog2(NUM_STATES + 1);
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [MASK_W-1:0] VALID_MASK = MASK_W'((1 << NUM_STATES) - 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_START_STATE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FINAL_STATES = 1'b1;

   typedef enum logic [1:0] {
      OP_ADD_EDGE = 2'd0,
      OP_WORD_CHAR = 2'd1,
      OP_END_WORD = 2'd2
   } opcode_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [MASK_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

endpackage

// ===== src/nfa_if.sv =====
interface nfa_req_if;
   import nfa_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [STATE_W-1:0] from_state;
   logic [STATE_W-1:0] to_state;
   logic [SYM_W-1:0]   symbol;

   modport source (output valid, output opcode, output from_state, output to_state,
                   output symbol, input ready);
   modport sink (input valid, input opcode, input from_state, input to_state,
                 input symbol, output ready);
endinterface

interface nfa_rsp_if;
   logic valid;
   logic ready;
   logic accepted;

   modport source (output valid, output accepted, input ready);
   modport sink (input valid, input accepted, output ready);
endinterface

// ===== src/nfa_store.sv =====
module nfa_store (
   input  logic                          clock,
   input  nfa_pkg::mem_req_type          mem_req,
   output logic [nfa_pkg::MASK_W-1:0]    rdata
);
   import nfa_pkg::*;

   logic [MASK_W-1:0] mem [STORE_DEPTH];
   logic [MASK_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rdata_ff <= mem[mem_req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/nfa_seq.sv =====
module nfa_seq (
   input  logic                              clock,
   input  logic                              reset,
   nfa_req_if.sink                           req_chan,
   nfa_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [nfa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [nfa_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output nfa_pkg::mem_req_type              mem_req,
   input  logic [nfa_pkg::MASK_W-1:0]        mem_rdata
);
   import nfa_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EDGE_RD,
      ST_EDGE_WR,
      ST_SCAN
   } state_type;

   state_type          state_ff;
   logic [ADDR_W-1:0]  clr_ff;
   logic [STATE_W-1:0] from_ff;
   logic [STATE_W-1:0] to_ff;
   logic [SYM_W-1:0]   sym_ff;
   logic [MASK_W-1:0]  active_ff;
   logic [MASK_W-1:0]  acc_ff;
   logic               in_word_ff;
   logic [SCAN_W-1:0]  scan_ff;
   logic               rsp_valid_ff;
   logic               rsp_acc_ff;
   logic [STATE_W-1:0] start_ff;
   logic [MASK_W-1:0]  final_ff;

   logic               req_xfer;
   logic               rsp_valid_in;
   logic [MASK_W-1:0]  start_mask;
   logic [MASK_W-1:0]  end_set;
   logic [STATE_W-1:0] prev_idx;
   logic [MASK_W-1:0]  scan_term;
   logic [MASK_W-1:0]  acc_in;
   logic               edge_ok;

   assign start_mask = ({1'b0, start_ff} < (STATE_W+1)'(NUM_STATES))
                       ? (MASK_W'(1) << start_ff) : '0;
   assign end_set    = in_word_ff ? active_ff : start_mask;
   assign edge_ok    = ({1'b0, req_chan.from_state} < (STATE_W+1)'(NUM_STATES))
                       && ({1'b0, req_chan.to_state} < (STATE_W+1)'(NUM_STATES));

   assign prev_idx  = STATE_W'(scan_ff - SCAN_W'(1));
   assign scan_term = ((scan_ff != '0) && active_ff[prev_idx]) ? mem_rdata : '0;
   assign acc_in    = acc_ff | scan_term;

   assign req_chan.ready = (state_ff == ST_IDLE)
                           && !((req_chan.opcode == OP_END_WORD) && rsp_valid_ff
                                && !rsp_chan.ready);
   assign req_xfer = req_chan.valid && req_chan.ready;

   assign rsp_valid_in = (req_xfer && (req_chan.opcode == OP_END_WORD))
                         || (rsp_valid_ff && !rsp_chan.ready);

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.accepted = rsp_acc_ff;

   always_comb begin
      mem_req = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_ff;
         end
         ST_EDGE_RD: begin
            mem_req.raddr = {from_ff, sym_ff};
         end
         ST_EDGE_WR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = {from_ff, sym_ff};
            mem_req.wdata = mem_rdata | (MASK_W'(1) << to_ff);
         end
         ST_SCAN: begin
            mem_req.raddr = {STATE_W'(scan_ff), sym_ff};
         end
         default: begin
            mem_req = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         active_ff    <= '0;
         in_word_ff   <= 1'b0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         start_ff     <= '0;
         final_ff     <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_START_STATE:  start_ff <= csr_wdata[STATE_W-1:0];
               CSR_FINAL_STATES: final_ff <= csr_wdata[MASK_W-1:0];
               default: ;
            endcase
         end

         rsp_valid_ff <= rsp_valid_in;

         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + ADDR_W'(1);
               if (clr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_xfer) begin
                  from_ff <= req_chan.from_state;
                  to_ff   <= req_chan.to_state;
                  sym_ff  <= req_chan.symbol;
                  case (req_chan.opcode)
                     OP_ADD_EDGE: begin
                        if (edge_ok) begin
                           state_ff <= ST_EDGE_RD;
                        end
                     end
                     OP_WORD_CHAR: begin
                        if (!in_word_ff) begin
                           active_ff  <= start_mask;
                           in_word_ff <= 1'b1;
                        end
                        acc_ff   <= '0;
                        scan_ff  <= '0;
                        state_ff <= ST_SCAN;
                     end
                     OP_END_WORD: begin
                        rsp_acc_ff   <= |(end_set & final_ff & VALID_MASK);
                        active_ff    <= '0;
                        in_word_ff   <= 1'b0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_EDGE_RD: begin
               state_ff <= ST_EDGE_WR;
            end
            ST_EDGE_WR: begin
               state_ff <= ST_IDLE;
            end
            ST_SCAN: begin
               acc_ff  <= acc_in;
               scan_ff <= scan_ff + SCAN_W'(1);
               if (scan_ff == SCAN_W'(NUM_STATES)) begin
                  active_ff <= acc_in & VALID_MASK;
                  state_ff  <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== src/nfa_word_acceptance_unit.sv =====
// nfa word acceptance: tracks the set of active states of a 16-state automaton whose
// labelled edges sit in a 4096 x 16 successor-mask memory indexed by {state, symbol}.
// after reset a clearing pass zeroes the memory; no transfer is taken until it
// ends, csr writes are taken throughout. an add-edge item reads the mask, then ors
// in the new edge and writes it back, a word character makes one memory read per
// state through the single read port, and an end-of-word item has its result held
// in an output register so the next item can transfer while it waits; only a
// further end-of-word item is held back until that result has transferred.
// start_state is sampled when a word begins (or at the end of an empty word) and
// final_states at end of word.
module nfa_word_acceptance_unit (
   input  logic                              clock,
   input  logic                              reset,
   nfa_req_if.sink                           req_chan,
   nfa_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [nfa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [nfa_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import nfa_pkg::*;

   mem_req_type       mem_req;
   logic [MASK_W-1:0] mem_rdata;

   nfa_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   nfa_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

endmodule
